// ----- src/fdh_pkg.sv -----
// ----------------------------------------------------------------------------
// fdh_pkg
// Shared types and codes for the framed message header check block.
// ----------------------------------------------------------------------------
package fdh_pkg;

  localparam int HDR_BYTES = 12;
  localparam int HDR_KEEP_W = (HDR_BYTES - 1) * 8;  // bytes held before the last one

  localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // header fault codes
  localparam logic [2:0] ERR_MAGIC    = 3'd0;
  localparam logic [2:0] ERR_VERSION  = 3'd1;
  localparam logic [2:0] ERR_ZERO_TY  = 3'd2;
  localparam logic [2:0] ERR_WRONG_TY = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_FRAME_VERSION = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN       = 2'd2;
  localparam logic [1:0] CFG_WANTED_TYPE   = 2'd3;

  localparam logic [31:0] RST_FRAME_MAGIC   = 32'd0;
  localparam logic [15:0] RST_FRAME_VERSION = 16'd1;
  localparam logic [31:0] RST_MAX_LEN       = 32'd1048576;
  localparam logic [15:0] RST_WANTED_TYPE   = 16'd0;

  typedef struct packed {
    logic [31:0] frame_magic;
    logic [15:0] frame_version;
    logic [31:0] max_payload_len;
    logic [15:0] wanted_type;
  } fdh_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] msg_type;
    logic        last;
    logic [2:0]  error_code;
  } fdh_word_t;

endpackage

// ----- src/fdh_front.sv -----
// ----------------------------------------------------------------------------
// fdh_front
// Collects header bytes, checks the header, tracks payload and emits words.
// ----------------------------------------------------------------------------
module fdh_front (
  input  logic             clk,
  input  logic             rst,
  input  fdh_pkg::fdh_cfg_t cfg,
  input  logic             accept,
  input  logic [7:0]       byte_in,
  output logic             emit,
  output fdh_pkg::fdh_word_t word
);
  import fdh_pkg::*;

  logic [HDR_KEEP_W-1:0] hdr;          // header bytes so far, oldest on top
  logic [3:0]            header_count;
  logic [3:0]            header_count_next;
  logic                  in_payload;
  logic                  in_payload_next;
  logic [31:0]           bytes_left;
  logic [31:0]           bytes_left_next;
  logic [15:0]           current_type;
  logic [15:0]           current_type_next;

  logic [95:0] full_hdr;
  logic [31:0] h_magic;
  logic [15:0] h_ver;
  logic [15:0] h_type;
  logic [31:0] h_len;
  logic        bad;
  logic [2:0]  bad_code;

  assign full_hdr = {hdr, byte_in};
  assign h_magic  = full_hdr[95:64];
  assign h_ver    = full_hdr[63:48];
  assign h_type   = full_hdr[47:32];
  assign h_len    = full_hdr[31:0];

  // first failing check wins
  always_comb begin
    bad      = 1'b1;
    bad_code = ERR_MAGIC;
    if (h_magic != cfg.frame_magic) begin
      bad_code = ERR_MAGIC;
    end else if (h_ver != cfg.frame_version) begin
      bad_code = ERR_VERSION;
    end else if (h_type == 16'd0) begin
      bad_code = ERR_ZERO_TY;
    end else if (cfg.wanted_type != 16'd0 && h_type != cfg.wanted_type) begin
      bad_code = ERR_WRONG_TY;
    end else if (h_len > cfg.max_payload_len) begin
      bad_code = ERR_TOO_LONG;
    end else begin
      bad = 1'b0;
    end
  end

  always_comb begin
    emit              = 1'b0;
    word              = '0;
    header_count_next = header_count;
    in_payload_next   = in_payload;
    bytes_left_next   = bytes_left;
    current_type_next = current_type;
    if (in_payload) begin
      emit          = 1'b1;
      word.kind     = KIND_DATA;
      word.data     = byte_in;
      word.msg_type = current_type;
      word.last     = (bytes_left <= 32'd1);
      if (bytes_left <= 32'd1) begin
        in_payload_next = 1'b0;
        bytes_left_next = 32'd0;
      end else begin
        bytes_left_next = bytes_left - 32'd1;
      end
    end else if (header_count == HDR_LAST) begin
      header_count_next = 4'd0;
      word.msg_type     = h_type;
      if (bad) begin
        emit            = 1'b1;
        word.kind       = KIND_REJECT;
        word.last       = 1'b1;
        word.error_code = bad_code;
      end else begin
        current_type_next = h_type;
        if (h_len == 32'd0) begin
          emit      = 1'b1;
          word.kind = KIND_EMPTY;
          word.last = 1'b1;
        end else begin
          in_payload_next = 1'b1;
          bytes_left_next = h_len;
        end
      end
    end else begin
      header_count_next = header_count + 4'd1;
    end
    if (!accept) begin
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= 4'd0;
      in_payload   <= 1'b0;
      bytes_left   <= 32'd0;
      current_type <= 16'd0;
    end else if (accept) begin
      header_count <= header_count_next;
      in_payload   <= in_payload_next;
      bytes_left   <= bytes_left_next;
      current_type <= current_type_next;
    end
  end

  // header store: no reset, every byte is shifted in before use
  always_ff @(posedge clk) begin
    if (accept && !in_payload) begin
      hdr <= {hdr[HDR_KEEP_W-9:0], byte_in};
    end
  end

endmodule

// ----- src/fdh_fifo.sv -----
// ----------------------------------------------------------------------------
// fdh_fifo
// Short word queue between the front and the back.
// ----------------------------------------------------------------------------
module fdh_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fdh_pkg::fdh_word_t push_word,
  input  logic               pop,
  output fdh_pkg::fdh_word_t pop_word,
  output logic               not_empty,
  output logic               full
);
  import fdh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fdh_word_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign pop_word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- src/fdh_back.sv -----
// ----------------------------------------------------------------------------
// fdh_back
// Output register: drains the queue and holds a word until it is taken.
// ----------------------------------------------------------------------------
module fdh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  fdh_pkg::fdh_word_t q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output fdh_pkg::fdh_word_t out_word
);
  import fdh_pkg::*;

  fdh_word_t held;
  logic      held_valid;

  assign q_pop     = q_not_empty && (!held_valid || out_ready);
  assign out_valid = held_valid;
  assign out_word  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (q_pop) begin
      held_valid <= 1'b1;
    end else if (out_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      held <= q_word;
    end
  end

endmodule

// ----- src/framed_message_header_check_top.sv -----
// ----------------------------------------------------------------------------
// framed_message_header_check_top
// Byte-stream deframer: 12-byte big-endian header check, payload pass-through.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid/in_ready   | byte_in
//  out      | out_valid/out_ready | kind, data_out, msg_type, last, error_code
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One byte per cycle while the queue has room; the front needs no extra
//  stage for the header check or the payload count. A result word passes
//  through the queue and then the output register before out_valid rises.
//  Sync reset clears counters, phase, queue and output valid; the header
//  store is not cleared. A stalled output fills the QUEUE_DEPTH-word queue,
//  after which in_ready drops. Bytes that give no result are still gated by
//  a full queue. cfg_ready is always high.
// ----------------------------------------------------------------------------
module framed_message_header_check_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_out,
  output logic [15:0] msg_type,
  output logic        last,
  output logic [2:0]  error_code,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fdh_pkg::*;

  fdh_cfg_t  cfg;
  logic      accept;
  logic      emit;
  fdh_word_t front_word;
  fdh_word_t q_word;
  fdh_word_t out_word;
  logic      q_not_empty;
  logic      q_full;
  logic      q_pop;

  // Register file. Writes must land only while idle; not enforced by the block.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_magic     <= RST_FRAME_MAGIC;
      cfg.frame_version   <= RST_FRAME_VERSION;
      cfg.max_payload_len <= RST_MAX_LEN;
      cfg.wanted_type     <= RST_WANTED_TYPE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_MAGIC:   cfg.frame_magic     <= cfg_data;
        CFG_FRAME_VERSION: cfg.frame_version   <= cfg_data[15:0];
        CFG_MAX_LEN:       cfg.max_payload_len <= cfg_data;
        CFG_WANTED_TYPE:   cfg.wanted_type     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front takes a byte whenever the queue has a free slot.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  fdh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .byte_in (byte_in),
    .emit    (emit),
    .word    (front_word)
  );

  fdh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_word (front_word),
    .pop       (q_pop),
    .pop_word  (q_word),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  fdh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_word      (q_word),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

  assign kind       = out_word.kind;
  assign data_out   = out_word.data;
  assign msg_type   = out_word.msg_type;
  assign last       = out_word.last;
  assign error_code = out_word.error_code;

endmodule

// ----- dv/framed_message_header_check_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framed_message_header_check_top_test
// Self-checking bench for the byte-stream deframer. A table of headers walks
// every check and the length extremes, then four random phases push framed
// traffic mixed with stray bytes and faulty headers under changing register
// settings and handshake pressure. Every result word is compared against an
// in-bench model of the header check and payload count.
// ----------------------------------------------------------------------------
module framed_message_header_check_top_test;
  import fdh_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 200;   // long output stall, fills the result queue
  localparam int SETTLE_CYCLES = 16;    // front latency plus queue, with margin
  localparam int PHASE_BYTES   = 135;
  localparam int N_ROWS        = 19;

  // idle profile per random phase, percent of cycles
  localparam int SND_IDLE  [4] = '{0, 57, 0, 35};
  localparam int RCV_STALL [4] = '{0, 0, 57, 35};

  // register sets used by the header table
  localparam fdh_cfg_t SET_RST      = '{RST_FRAME_MAGIC, RST_FRAME_VERSION, RST_MAX_LEN,
                                        RST_WANTED_TYPE};
  localparam fdh_cfg_t SET_ALL_ONES = '{32'hFFFFFFFF, 16'hFFFF, 32'd3, 16'hFFFF};
  localparam fdh_cfg_t SET_TIGHT    = '{32'h5A5AA5A5, 16'h0102, 32'd0, 16'h0001};
  localparam fdh_cfg_t SET_OPEN     = '{32'h00000000, 16'h0000, 32'hFFFFFFFF, 16'h0000};

  // One header per row. Rows with typed set carry the result kind and fault
  // code; the rest are left to the model and carry a payload of length bytes.
  typedef struct packed {
    fdh_cfg_t    cfg;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] msg_ty;
    logic [31:0] length;
    logic        typed;
    logic [1:0]  want_kind;
    logic [2:0]  want_err;
  } hdr_row_t;

  localparam hdr_row_t HDR_TABLE [N_ROWS] = '{
    // registers straight out of reset: all-zero header trips on version
    '{SET_RST, 32'h00000000, 16'h0000, 16'h0000, 32'h00000000, 1'b1, KIND_REJECT, ERR_VERSION},
    '{SET_RST, 32'h00000000, 16'h0001, 16'h0000, 32'h00000000, 1'b1, KIND_REJECT, ERR_ZERO_TY},
    '{SET_RST, 32'h00000000, 16'h0001, 16'h0001, 32'h00000000, 1'b1, KIND_EMPTY, '0},
    // magic, version and length wrong at once: magic is reported first
    '{SET_RST, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, KIND_REJECT, ERR_MAGIC},
    '{SET_RST, 32'h00000000, 16'h0001, 16'hFFFF, 32'hFFFFFFFF, 1'b1, KIND_REJECT, ERR_TOO_LONG},
    '{SET_RST, 32'h00000000, 16'h0001, 16'h00AB, 32'h00000001, 1'b0, '0, '0},
    '{SET_RST, 32'h00000000, 16'h0001, 16'h8000, 32'h00000005, 1'b0, '0, '0},
    // one past the reset maximum
    '{SET_RST, 32'h00000000, 16'h0001, 16'h0001, 32'h00100001, 1'b1, KIND_REJECT, ERR_TOO_LONG},
    '{SET_ALL_ONES, 32'hFFFFFFFF, 16'hFFFF, 16'h1234, 32'h0, 1'b1, KIND_REJECT, ERR_WRONG_TY},
    // length equal to the maximum passes, one more fails
    '{SET_ALL_ONES, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'h3, 1'b0, '0, '0},
    '{SET_ALL_ONES, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'h4, 1'b1, KIND_REJECT, ERR_TOO_LONG},
    '{SET_ALL_ONES, 32'hFFFFFFFE, 16'hFFFF, 16'hFFFF, 32'h0, 1'b1, KIND_REJECT, ERR_MAGIC},
    '{SET_ALL_ONES, 32'hFFFFFFFF, 16'hFFFE, 16'hFFFF, 32'h0, 1'b1, KIND_REJECT, ERR_VERSION},
    // zero type wins over the wanted-type check
    '{SET_ALL_ONES, 32'hFFFFFFFF, 16'hFFFF, 16'h0000, 32'h0, 1'b1, KIND_REJECT, ERR_ZERO_TY},
    // maximum of zero: only empty messages get through
    '{SET_TIGHT, 32'h5A5AA5A5, 16'h0102, 16'h0001, 32'h0, 1'b1, KIND_EMPTY, '0},
    '{SET_TIGHT, 32'h5A5AA5A5, 16'h0102, 16'h0001, 32'h1, 1'b1, KIND_REJECT, ERR_TOO_LONG},
    '{SET_TIGHT, 32'h5A5AA5A5, 16'h0102, 16'h0002, 32'h0, 1'b1, KIND_REJECT, ERR_WRONG_TY},
    '{SET_OPEN, 32'h00000000, 16'h0000, 16'h7FFF, 32'h2, 1'b0, '0, '0},
    '{SET_OPEN, 32'h00000000, 16'h0000, 16'h0001, 32'h11, 1'b0, '0, '0}
  };

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  byte_in   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  kind;
  logic [7:0]  data_out;
  logic [15:0] msg_type;
  logic        last;
  logic [2:0]  error_code;
  logic        cfg_ready;

  framed_message_header_check_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_out   (data_out),
    .msg_type   (msg_type),
    .last       (last),
    .error_code (error_code),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Deframer model: header bytes, phase, payload count and register copy
  // --------------------------------------------------------------------------
  logic [7:0]  hdr_bytes [HDR_BYTES];
  logic [3:0]  hdr_cnt;
  logic        in_body;
  logic [31:0] body_left;
  logic [15:0] body_type;
  fdh_cfg_t    cfg_model;

  fdh_word_t   result_q [$];   // words the block owes, oldest first
  fdh_word_t   typed_q  [$];   // table words that replace the model's next word

  int          err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int          sent_cnt  = 0;
  int          snd_idle  = 0;
  int          rcv_stall = 0;
  bit          hold_req  = 1'b0;

  // Feed one byte to the model; returns 1 with the word it produces, if any.
  function automatic bit deframe_byte(input logic [7:0] b, output fdh_word_t w);
    logic [31:0] magic;
    logic [31:0] len;
    logic [15:0] ver;
    logic [15:0] ty;
    logic [2:0]  code;
    bit          bad;
    w    = '0;
    code = '0;
    if (in_body) begin
      w.kind     = KIND_DATA;
      w.data     = b;
      w.msg_type = body_type;
      w.last     = (body_left <= 32'd1);
      if (w.last) begin
        in_body   = 1'b0;
        body_left = '0;
      end else begin
        body_left = body_left - 32'd1;
      end
      return 1'b1;
    end
    hdr_bytes[hdr_cnt] = b;
    if (hdr_cnt != HDR_LAST) begin
      hdr_cnt = hdr_cnt + 4'd1;
      return 1'b0;
    end
    hdr_cnt = '0;
    magic = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
    ver   = {hdr_bytes[4], hdr_bytes[5]};
    ty    = {hdr_bytes[6], hdr_bytes[7]};
    len   = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
    // checks in priority order, first failure wins
    bad = 1'b1;
    if (magic != cfg_model.frame_magic) code = ERR_MAGIC;
    else if (ver != cfg_model.frame_version) code = ERR_VERSION;
    else if (ty == '0) code = ERR_ZERO_TY;
    else if (cfg_model.wanted_type != '0 && ty != cfg_model.wanted_type) code = ERR_WRONG_TY;
    else if (len > cfg_model.max_payload_len) code = ERR_TOO_LONG;
    else bad = 1'b0;
    w.msg_type = ty;
    if (bad) begin
      w.kind       = KIND_REJECT;
      w.last       = 1'b1;
      w.error_code = code;
      return 1'b1;
    end
    body_type = ty;
    if (len == '0) begin
      w.kind = KIND_EMPTY;
      w.last = 1'b1;
      return 1'b1;
    end
    body_left = len;
    in_body   = 1'b1;
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: all handshakes are sampled at the rising edge, before the DUT's
  // own updates land. Output is checked ahead of prediction so a word that
  // shows up uninvited never meets an expectation made on the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    fdh_word_t w;
    if (rst) begin
      hdr_cnt   = '0;
      in_body   = 1'b0;
      body_left = '0;
      body_type = '0;
      cfg_model = SET_RST;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result word with none expected: kind %0d data_out %0h", kind, data_out);
          err_cnt++;
        end else begin
          w = result_q.pop_front();
          if (kind !== w.kind) begin
            $error("kind: expected %0d, actual %0d", w.kind, kind);
            err_cnt++;
          end
          if (data_out !== w.data) begin
            $error("data_out: expected %0h, actual %0h", w.data, data_out);
            err_cnt++;
          end
          if (msg_type !== w.msg_type) begin
            $error("msg_type: expected %0h, actual %0h", w.msg_type, msg_type);
            err_cnt++;
          end
          if (last !== w.last) begin
            $error("last: expected %0d, actual %0d", w.last, last);
            err_cnt++;
          end
          if (error_code !== w.error_code) begin
            $error("error_code: expected %0d, actual %0d", w.error_code, error_code);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (deframe_byte(byte_in, w)) begin
          if (typed_q.size() != 0) w = typed_q.pop_front();
          result_q = {result_q, w};
        end
      end
      // register writes only land while idle, so no byte shares this edge
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_MAGIC:   cfg_model.frame_magic     = cfg_data;
          CFG_FRAME_VERSION: cfg_model.frame_version   = cfg_data[15:0];
          CFG_MAX_LEN:       cfg_model.max_payload_len = cfg_data;
          CFG_WANTED_TYPE:   cfg_model.wanted_type     = cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls per phase; on request one long hold-off, counted
  // here, while the sender keeps pushing.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_cnt;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_stall);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one byte and hold it until taken. Valid is only dropped for idle
  // slots, never in the step where the next byte goes up.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  // Header big-endian, then nbody random payload bytes. A typed word is queued
  // once the eleventh byte is in: that byte never yields a result, so the
  // word can only pair with the twelfth.
  task automatic send_frame(input logic [31:0] magic, input logic [15:0] ver,
                            input logic [15:0] ty, input logic [31:0] len,
                            input int nbody, input bit typed, input fdh_word_t want);
    logic [95:0] hdr;
    hdr = {magic, ver, ty, len};
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (typed && i == HDR_BYTES - 1) typed_q = {typed_q, want};
      send_byte(hdr[95 - 8 * i -: 8]);
    end
    for (int i = 0; i < nbody; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Mostly good frames for the current registers, one in five with a fault.
  task automatic send_random_frame(input fdh_cfg_t c, output int nbody);
    logic [31:0] magic;
    logic [31:0] len;
    logic [31:0] cap;
    logic [15:0] ver;
    logic [15:0] ty;
    logic [2:0]  fault;
    bit          bad;
    magic = c.frame_magic;
    ver   = c.frame_version;
    ty    = (c.wanted_type != '0) ? c.wanted_type : 16'($urandom_range(1, 65535));
    cap   = (c.max_payload_len < 32'd24) ? c.max_payload_len : 32'd24;
    len   = $urandom_range(0, cap);
    bad   = ($urandom_range(0, 99) < 20);
    fault = 3'($urandom_range(0, 4));
    if (bad) begin
      case (fault)
        ERR_MAGIC:    magic ^= 32'($urandom_range(1, 32'hFFFFFFFF));
        ERR_VERSION:  ver ^= 16'($urandom_range(1, 65535));
        ERR_WRONG_TY: begin
          if (c.wanted_type != '0) begin
            do ty = 16'($urandom_range(1, 65535)); while (ty == c.wanted_type);
          end else begin
            ty = '0;
          end
        end
        ERR_TOO_LONG: begin
          if (c.max_payload_len != 32'hFFFFFFFF) begin
            if ($urandom_range(0, 1) == 0) len = c.max_payload_len + 32'd1;
            else len = $urandom_range(c.max_payload_len + 32'd1, 32'hFFFFFFFF);
          end else begin
            ty = '0;
          end
        end
        default:      ty = '0;
      endcase
    end
    nbody = bad ? 0 : int'(len);
    send_frame(magic, ver, ty, len, nbody, 1'b0, '0);
  endtask

  // Wait out every owed word, then the front latency, before touching registers.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Upper bits of the 16-bit registers get junk: the block must mask them.
  task automatic load_config(input fdh_cfg_t c);
    write_reg(CFG_FRAME_MAGIC, c.frame_magic);
    write_reg(CFG_FRAME_VERSION, {16'($urandom), c.frame_version});
    write_reg(CFG_MAX_LEN, c.max_payload_len);
    write_reg(CFG_WANTED_TYPE, {16'($urandom), c.wanted_type});
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    fdh_cfg_t cur_cfg;
    fdh_cfg_t ph_cfg;
    hdr_row_t row;
    int       skew;
    int       k;
    int       nbody;
    int       ph_start;
    skew = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // header table, light idling on both sides
    cur_cfg   = SET_RST;
    snd_idle  = 20;
    rcv_stall = 20;
    for (int r = 0; r < N_ROWS; r++) begin
      row = HDR_TABLE[r];
      if (row.cfg != cur_cfg) begin
        drain();
        load_config(row.cfg);
        cur_cfg = row.cfg;
      end
      send_frame(row.magic, row.version, row.msg_ty, row.length,
                 row.typed ? 0 : int'(row.length), row.typed,
                 fdh_word_t'{row.want_kind, 8'h00, row.msg_ty, 1'b1, row.want_err});
    end

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: ph_cfg = '{32'($urandom), 16'($urandom), 32'hFFFFFFFF, 16'h0000};
        1: ph_cfg = '{32'($urandom), 16'h0000, 32'($urandom_range(8, 40)),
                      16'($urandom_range(1, 65535))};
        2: ph_cfg = '{32'($urandom), 16'hFFFF, 32'($urandom_range(1, 20)), 16'hFFFF};
        default: ph_cfg = '{32'($urandom), 16'($urandom), 32'($urandom_range(0, 30)),
                            16'h0000};
      endcase
      drain();
      load_config(ph_cfg);
      snd_idle  = SND_IDLE[ph];
      rcv_stall = RCV_STALL[ph];
      ph_start  = sent_cnt;
      if (ph == 0) begin
        // long payload against a stalled output: queue fills, input backs up
        hold_req = 1'b1;
        send_frame(ph_cfg.frame_magic, ph_cfg.frame_version, 16'h00C3, 32'd40, 40,
                   1'b0, '0);
      end
      while (sent_cnt - ph_start < PHASE_BYTES) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray bytes knock the header boundary out of step
          k = $urandom_range(1, HDR_BYTES);
          repeat (k) send_byte(8'($urandom));
          skew = (skew + k) % HDR_BYTES;
        end else begin
          // usually pad back into step; otherwise the frame goes in skewed
          if (skew != 0 && $urandom_range(0, 3) != 0) begin
            repeat (HDR_BYTES - skew) send_byte(8'($urandom));
            skew = 0;
          end
          send_random_frame(ph_cfg, nbody);
          if (skew != 0) skew = (skew + nbody) % HDR_BYTES;
        end
      end
    end

    drain();
    if (result_q.size() != 0 || typed_q.size() != 0) begin
      $error("%0d result words never arrived", result_q.size() + typed_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
